// ===== sv/sorted_date_table_macros.svh =====
// Assertion macros used by the sorted date table datapath.
`ifndef SORTED_DATE_TABLE_MACROS_SVH
`define SORTED_DATE_TABLE_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/sdt_pkg.sv =====
// Types and constants shared by the sorted date table modules.
`timescale 1ns / 1ps
package sdt_pkg;

  localparam int unsigned KeyWidth = 21;
  localparam int unsigned OutCntWidth = 7;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_INS_KEY,
    S_REM_RD,
    S_REM_WR,
    S_RES_OK,
    S_RES_DUP,
    S_RES_FULL,
    S_RES_ABSENT
  } ctrl_state_e;

  typedef struct packed {
    logic    load_req;
    logic    scan_rd;
    logic    scan_next;
    logic    slot_take;
    logic    ins_setup;
    logic    rem_setup;
    logic    shift_rd;
    logic    shift_wr;
    logic    key_wr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_e res_status;
    logic    res_pos;
  } dp_cmd_t;

  typedef struct packed {
    logic       scan_end;
    logic       key_less;
    logic       hit;
    logic       full;
    logic       shift_done;
    logic       out_busy;
    logic [1:0] cmd;
  } dp_sts_t;

endpackage

// ===== sv/sdt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module sdt_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sdt_ctrl.sv =====
// Controller state machine that sequences the scan, shift and result steps.
`timescale 1ns / 1ps
module sdt_ctrl import sdt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        state_d = sts_i.scan_end ? S_DECIDE : S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        state_d = sts_i.key_less ? S_SCAN : S_DECIDE;
      end
      S_DECIDE: begin
        case (sts_i.cmd)
          CMD_INSERT: begin
            if (sts_i.hit) state_d = S_RES_DUP;
            else if (sts_i.full) state_d = S_RES_FULL;
            else state_d = S_INS_RD;
          end
          CMD_REMOVE: begin
            state_d = sts_i.hit ? S_REM_RD : S_RES_ABSENT;
          end
          default: begin
            state_d = sts_i.hit ? S_RES_OK : S_RES_ABSENT;
          end
        endcase
      end
      S_INS_RD: begin
        state_d = sts_i.shift_done ? S_INS_KEY : S_INS_WR;
      end
      S_INS_WR: begin
        state_d = S_INS_RD;
      end
      S_INS_KEY: begin
        state_d = S_RES_OK;
      end
      S_REM_RD: begin
        state_d = sts_i.shift_done ? S_RES_OK : S_REM_WR;
      end
      S_REM_WR: begin
        state_d = S_REM_RD;
      end
      S_RES_OK, S_RES_DUP, S_RES_FULL, S_RES_ABSENT: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan_rd = !sts_i.scan_end;
        cmd_o.slot_take = sts_i.scan_end;
      end
      S_SCAN_WAIT: begin
        cmd_o.scan_next = sts_i.key_less;
        cmd_o.slot_take = !sts_i.key_less;
      end
      S_DECIDE: begin
        cmd_o.ins_setup = (sts_i.cmd == CMD_INSERT);
        cmd_o.rem_setup = (sts_i.cmd == CMD_REMOVE);
      end
      S_INS_RD: begin
        cmd_o.shift_rd = !sts_i.shift_done;
      end
      S_INS_WR: begin
        cmd_o.shift_wr = 1'b1;
      end
      S_INS_KEY: begin
        cmd_o.key_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      S_REM_RD: begin
        cmd_o.shift_rd = !sts_i.shift_done;
        cmd_o.cnt_dec = sts_i.shift_done;
      end
      S_REM_WR: begin
        cmd_o.shift_wr = 1'b1;
      end
      S_RES_OK: begin
        cmd_o.res_load = !sts_i.out_busy;
        cmd_o.res_status = ST_OK;
        cmd_o.res_pos = 1'b1;
      end
      S_RES_DUP: begin
        cmd_o.res_load = !sts_i.out_busy;
        cmd_o.res_status = ST_DUP;
        cmd_o.res_pos = 1'b1;
      end
      S_RES_FULL: begin
        cmd_o.res_load = !sts_i.out_busy;
        cmd_o.res_status = ST_FULL;
      end
      S_RES_ABSENT: begin
        cmd_o.res_load = !sts_i.out_busy;
        cmd_o.res_status = ST_ABSENT;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== sv/sdt_dp.sv =====
// Datapath with the request registers, scan index, entry count and result register.
`timescale 1ns / 1ps
`include "sorted_date_table_macros.svh"
module sdt_dp import sdt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dp_cmd_t                        cmd_i,
  output dp_sts_t                        sts_o,
  input  logic [1:0]                     command_i,
  input  logic [11:0]                    year_i,
  input  logic [3:0]                     month_i,
  input  logic [4:0]                     day_i,
  output logic                           ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr_o,
  output logic [KeyWidth-1:0]            ram_wdata_o,
  output logic                           ram_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr_o,
  input  logic [KeyWidth-1:0]            ram_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [OutCntWidth-1:0]         position_o,
  output logic [OutCntWidth-1:0]         entry_count_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

  logic [1:0]             cmd_q;
  logic [KeyWidth-1:0]    key_q;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          slot_q;
  logic                   hit_q;
  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q;
  status_e                res_status_q;
  logic [OutCntWidth-1:0] res_pos_q;
  logic [OutCntWidth-1:0] res_cnt_q;

  logic          is_insert;
  logic          key_eq;
  logic [CW:0]   idx_inc;
  logic [CW:0]   slot_inc;
  logic [CW-1:0] rd_idx;

  assign is_insert = (cmd_q == CMD_INSERT);
  assign key_eq    = (ram_rdata_i == key_q);
  assign idx_inc   = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
  assign slot_inc  = {1'b0, slot_q} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load_req) begin
      idx_d = '0;
    end else if (cmd_i.scan_next) begin
      idx_d = idx_inc[CW-1:0];
    end else if (cmd_i.ins_setup) begin
      idx_d = count_q;
    end else if (cmd_i.rem_setup) begin
      idx_d = slot_q;
    end else if (cmd_i.shift_wr) begin
      idx_d = is_insert ? (idx_q - {{(CW-1){1'b0}}, 1'b1}) : idx_inc[CW-1:0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + {{(CW-1){1'b0}}, 1'b1};
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - {{(CW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load_req) begin
      cmd_q <= command_i;
      key_q <= {year_i, month_i, day_i};
    end
    if (cmd_i.slot_take) begin
      slot_q <= idx_q;
      hit_q  <= key_eq && !sts_o.scan_end;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_pos_q    <= cmd_i.res_pos ? OutCntWidth'(slot_inc) : '0;
      res_cnt_q    <= OutCntWidth'(count_q);
    end
  end

  // Insert shifts move each entry up from the one below; removes pull from above.
  always_comb begin
    rd_idx = idx_q;
    if (cmd_i.shift_rd) begin
      rd_idx = is_insert ? (idx_q - {{(CW-1){1'b0}}, 1'b1}) : idx_inc[CW-1:0];
    end
  end

  assign ram_re_o    = cmd_i.scan_rd || cmd_i.shift_rd;
  assign ram_raddr_o = rd_idx[AW-1:0];
  assign ram_we_o    = cmd_i.shift_wr || cmd_i.key_wr;
  assign ram_waddr_o = cmd_i.key_wr ? slot_q[AW-1:0] : idx_q[AW-1:0];
  assign ram_wdata_o = cmd_i.key_wr ? key_q : ram_rdata_i;

  assign sts_o.scan_end   = (idx_q >= count_q);
  assign sts_o.key_less   = (ram_rdata_i < key_q);
  assign sts_o.hit        = hit_q;
  assign sts_o.full       = (count_q >= Depth);
  assign sts_o.shift_done = is_insert ? (idx_q <= slot_q) : (idx_inc >= {1'b0, count_q});
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign sts_o.cmd        = cmd_q;

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_status_q;
  assign position_o    = res_pos_q;
  assign entry_count_o = res_cnt_q;

  `SDT_ASSERT_ALWAYS(a_count_in_range, !rst_ni || (count_q <= Depth), "entry count exceeds table depth")
  `SDT_ASSERT(a_no_overwrite, out_valid_q && !out_ready_i |-> !cmd_i.res_load,
              "result loaded while the previous one is stalled")
  `SDT_ASSERT(a_no_underflow, cmd_i.cnt_dec |-> count_q != '0, "remove from an empty table")
  `SDT_ASSERT(a_insert_room, cmd_i.key_wr |-> count_q < Depth, "insert into a full table")

endmodule

// ===== sv/sorted_date_table.sv =====
// Sorted date table: keeps distinct dates in ascending order and serves
// insert, remove and find requests with one result per request.
// The input channel (in_valid_i/in_ready_o) carries command, year, month
// and day; the output channel (out_valid_o/out_ready_i) returns status,
// 1-based position and the entry count after the request.
// A request is taken only while the block is idle. The keys sit in a RAM
// with one read and one write port and a registered read, so each entry
// visited takes a read state and a compare state. A find scans up to its
// slot; insert and remove scan to the slot and then shift the later
// entries, with a read state and a write state for each entry moved.
// The finished result is held in an output register, so the next request
// is accepted while that result waits; a stalled receiver holds only the
// following result back. Reset clears the entry count and the output
// valid; the key RAM is not cleared and needs no clearing pass, since only
// entries below the count are ever read.
`timescale 1ns / 1ps
module sorted_date_table import sdt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             command_i,
  input  logic [11:0]            year_i,
  input  logic [3:0]             month_i,
  input  logic [4:0]             day_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic [OutCntWidth-1:0] position_o,
  output logic [OutCntWidth-1:0] entry_count_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  dp_cmd_t             dp_cmd;
  dp_sts_t             dp_sts;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [KeyWidth-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [KeyWidth-1:0] ram_rdata;

  sdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  sdt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .command_i     (command_i),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

  sdt_ram #(
    .WIDTH (KeyWidth),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== dv/sorted_date_table_test.sv =====
// Self-checking test of the sorted date table: directed, full-table, back-pressure and random requests.
`timescale 1ns / 1ps
module sorted_date_table_test import sdt_pkg::*;;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned LongHold = 700;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned RandomRequests = 1550;
  localparam logic [1:0] CmdSpare = 2'd3;

  typedef struct packed {
    status_e                status;
    logic [OutCntWidth-1:0] position;
    logic [OutCntWidth-1:0] entry_count;
  } date_result_t;

  logic                   clk = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             command = CMD_FIND;
  logic [11:0]            year = '0;
  logic [3:0]             month = '0;
  logic [4:0]             day = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [OutCntWidth-1:0] position;
  logic [OutCntWidth-1:0] entry_count;

  logic [KeyWidth-1:0] held_dates[TableDepth];
  int unsigned         held_count = 0;
  date_result_t        pending_results[$];
  int unsigned         mismatches = 0;
  bit                  send_idle = 1'b1;
  bit                  recv_idle = 1'b1;
  bit                  long_hold_req = 1'b0;

  sorted_date_table #(
    .TABLE_DEPTH(TableDepth)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .command_i    (command),
    .year_i       (year),
    .month_i      (month),
    .day_i        (day),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .position_o   (position),
    .entry_count_o(entry_count)
  );

  initial forever #2 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic logic [KeyWidth-1:0] random_date();
    return KeyWidth'($urandom);
  endfunction

  function automatic date_result_t apply_request(logic [1:0] cmd, logic [KeyWidth-1:0] key);
    date_result_t r;
    int unsigned  slot;
    int unsigned  i;
    logic         hit;
    slot = 0;
    while (slot < held_count && held_dates[slot] < key) slot++;
    hit = (slot < held_count) && (held_dates[slot] == key);
    r.status = ST_ABSENT;
    r.position = '0;
    if (cmd == CMD_INSERT) begin
      if (hit) begin
        r.status = ST_DUP;
        r.position = OutCntWidth'(slot + 1);
      end else if (held_count >= TableDepth) begin
        r.status = ST_FULL;
      end else begin
        for (i = held_count; i > slot; i--) held_dates[i] = held_dates[i - 1];
        held_dates[slot] = key;
        held_count++;
        r.status = ST_OK;
        r.position = OutCntWidth'(slot + 1);
      end
    end else if (cmd == CMD_REMOVE) begin
      if (hit) begin
        for (i = slot; i + 1 < held_count; i++) held_dates[i] = held_dates[i + 1];
        held_count--;
        r.status = ST_OK;
        r.position = OutCntWidth'(slot + 1);
      end
    end else if (hit) begin
      r.status = ST_OK;
      r.position = OutCntWidth'(slot + 1);
    end
    r.entry_count = OutCntWidth'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_request(logic [1:0] cmd, logic [KeyWidth-1:0] key);
    int unsigned gap;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    year <= key[20:9];
    month <= key[8:5];
    day <= key[4:0];
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(apply_request(cmd, key));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_result();
    date_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no request outstanding", entry_count, 0);
    end else begin
      want = pending_results.pop_front();
      if (status != want.status) report_mismatch("status", status, want.status);
      if (position != want.position) report_mismatch("position", position, want.position);
      if (entry_count != want.entry_count) begin
        report_mismatch("entry count", entry_count, want.entry_count);
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst_ni && out_valid && out_ready) check_result();
  end

  initial begin : receiver
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        stall = LongHold;
        long_hold_req = 1'b0;
      end else if (stall == 0 && recv_idle && $urandom_range(99) < 20) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic test_directed();
    send_request(CMD_FIND, {12'd2000, 4'd6, 5'd15});
    send_request(CMD_REMOVE, {12'd2000, 4'd6, 5'd15});
    send_request(CmdSpare, {12'd2000, 4'd6, 5'd15});
    send_request(CMD_INSERT, {12'd2000, 4'd6, 5'd15});
    send_request(CMD_INSERT, {12'd0, 4'd0, 5'd0});
    send_request(CMD_INSERT, {12'd4095, 4'd15, 5'd31});
    send_request(CMD_INSERT, {12'd2000, 4'd6, 5'd14});
    send_request(CMD_INSERT, {12'd2000, 4'd6, 5'd16});
    send_request(CMD_INSERT, {12'd2000, 4'd5, 5'd31});
    send_request(CMD_INSERT, {12'd2000, 4'd7, 5'd1});
    send_request(CMD_INSERT, {12'd1999, 4'd12, 5'd31});
    send_request(CMD_INSERT, {12'd2001, 4'd1, 5'd1});
    send_request(CMD_INSERT, {12'd2000, 4'd6, 5'd15});
    send_request(CMD_FIND, {12'd2000, 4'd6, 5'd15});
    send_request(CMD_FIND, {12'd2000, 4'd6, 5'd17});
    send_request(CmdSpare, {12'd4095, 4'd15, 5'd31});
    send_request(CmdSpare, {12'd4095, 4'd15, 5'd30});
    send_request(CMD_REMOVE, {12'd2000, 4'd6, 5'd15});
    send_request(CMD_REMOVE, {12'd2000, 4'd6, 5'd15});
    send_request(CMD_REMOVE, {12'd0, 4'd0, 5'd0});
    send_request(CMD_REMOVE, {12'd4095, 4'd15, 5'd31});
    send_request(CMD_FIND, {12'd2000, 4'd6, 5'd16});
    drain();
  endtask

  task automatic test_full_table();
    logic [KeyWidth-1:0] key;
    while (held_count < TableDepth) send_request(CMD_INSERT, random_date());
    send_request(CMD_INSERT, random_date());
    send_request(CMD_INSERT, held_dates[0]);
    send_request(CMD_INSERT, held_dates[TableDepth - 1]);
    send_request(CmdSpare, held_dates[TableDepth / 2]);
    key = held_dates[TableDepth / 2];
    send_request(CMD_REMOVE, key);
    send_request(CMD_INSERT, key);
    send_request(CMD_INSERT, {12'd4095, 4'd15, 5'd31});
    while (held_count > 0) begin
      key = held_dates[$urandom_range(held_count - 1)];
      if ($urandom_range(3) == 0) send_request(CMD_FIND, key);
      send_request(CMD_REMOVE, key);
    end
    send_request(CMD_FIND, key);
    drain();
  endtask

  task automatic test_back_pressure();
    send_idle = 1'b0;
    long_hold_req = 1'b1;
    repeat (4) send_request(CMD_INSERT, random_date());
    send_request(CMD_FIND, held_dates[0]);
    send_request(CMD_REMOVE, held_dates[0]);
    send_request(CMD_INSERT, random_date());
    send_request(CMD_FIND, random_date());
    send_idle = 1'b1;
    drain();
  endtask

  task automatic test_random(int unsigned total);
    logic [KeyWidth-1:0] pool[$];
    logic [KeyWidth-1:0] key;
    logic [1:0]          cmd;
    int unsigned         sent;
    int unsigned         ins_pct;
    int unsigned         rem_pct;
    int unsigned         roll;
    int unsigned         base_year;
    sent = 0;
    while (sent < total) begin
      pool.delete();
      base_year = $urandom_range(4092);
      repeat ($urandom_range(150, 20)) begin
        key = random_date();
        if ($urandom_range(1) == 0) key[20:9] = 12'(base_year + $urandom_range(3));
        pool.push_back(key);
      end
      ins_pct = $urandom_range(70, 25);
      rem_pct = $urandom_range(90 - ins_pct, 5);
      send_idle = ($urandom_range(3) != 0);
      recv_idle = ($urandom_range(3) != 0);
      repeat ($urandom_range(250, 100)) begin
        roll = $urandom_range(99);
        if (roll < ins_pct) cmd = CMD_INSERT;
        else if (roll < ins_pct + rem_pct) cmd = CMD_REMOVE;
        else if (roll < 96) cmd = CMD_FIND;
        else cmd = CmdSpare;
        if ($urandom_range(99) < 85) key = pool[$urandom_range(pool.size() - 1)];
        else key = random_date();
        send_request(cmd, key);
        sent++;
      end
      if ($urandom_range(2) == 0) drain();
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    test_directed();
    test_full_table();
    test_back_pressure();
    test_random(RandomRequests);
    drain();
    repeat (SettleCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never returned", 0, pending_results.size());
    end
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sdt_pkg.sv
sv/sdt_ram.sv
sv/sdt_ctrl.sv
sv/sdt_dp.sv
sv/sorted_date_table.sv
dv/sorted_date_table_test.sv
